// ===== rtl/dcpi_pkg.sv =====
// Shared types, command codes and calibration constants for the DAC interpolator.
`default_nettype none
package dcpi_pkg;

  localparam logic [1:0] CMD_CONVERT = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  localparam logic [11:0] CODE_MAX = 12'd4095;

  // Floor division by 3000 or 4000 of any value below 2**24 is exact as
  // (a * RECIP) >> RECIP_SHIFT with these reciprocals.
  localparam int RECIP_SHIFT = 36;
  localparam logic [24:0] RECIP_3000 = 25'd22906493;
  localparam logic [24:0] RECIP_4000 = 25'd17179870;
  localparam logic [10:0] HALF_3000 = 11'd1500;
  localparam logic [10:0] HALF_4000 = 11'd2000;

  // One classified command as it travels from the front end to the back end.
  typedef struct packed {
    logic [1:0]  cmd;
    logic        mode;
    logic [2:0]  ch;
    logic [1:0]  pt;
    logic [1:0]  seg;
    logic [11:0] dx;
    logic [11:0] code;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEG_HI,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_READ
  } back_state_t;

  function automatic logic signed [14:0] bp_mv(input logic mode, input logic [1:0] idx);
    logic signed [14:0] v;
    case ({mode, idx})
      3'b000:  v = -15'sd3000;
      3'b001:  v = 15'sd0;
      3'b010:  v = 15'sd3000;
      3'b011:  v = 15'sd7000;
      3'b100:  v = 15'sd0;
      3'b101:  v = 15'sd3000;
      3'b110:  v = 15'sd6000;
      default: v = 15'sd10000;
    endcase
    return v;
  endfunction

  function automatic logic [11:0] ideal_code(input logic [1:0] idx);
    logic [11:0] v;
    case (idx)
      2'd0:    v = 12'd0;
      2'd1:    v = 12'd1229;
      2'd2:    v = 12'd2457;
      default: v = 12'd4095;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dac_calibrated_piecewise_interp.sv =====
// Top level of the calibrated piecewise-linear DAC code converter.
`default_nettype none
// Converts a millivolt target into a 12-bit DAC code through a per-channel
// calibration store of four measured codes for each of two range modes
// (range_mode 0: breakpoints -3000/0/3000/7000 mV, 1: 0/3000/6000/10000 mV).
// Commands enter through a queue-like port (push/full) and every command
// gives exactly one beat on the result side (empty/pop): the converted code,
// the code read back, the stored code after a write, or zero for the unused
// command. A two-entry queue sits between the classifying front end and the
// executing back end, so up to two commands are taken while a result waits.
// The back end runs one command at a time and starts only when its result
// register is free. A convert steps through SEG_HI, MUL, DIV and FIN, as the
// single read port of the store is used twice (low and high segment point)
// and the interpolation and constant-divide multiplies each have a stage of
// their own; a read passes READ, a write ends on acceptance. Out of reset the
// store holds the ideal codes 0, 1229, 2457, 4095 for every channel via
// per-entry valid bits, so no clearing pass is needed. The user must write
// range_mode only while the block idles; the block does not enforce this.
module dac_calibrated_piecewise_interp #(
  parameter int CHANNELS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         cmd,
  input  wire logic signed [14:0] voltage_mv,
  input  wire logic [2:0]         channel,
  input  wire logic [1:0]         point_index,
  input  wire logic [15:0]        code_value,
  input  wire logic               range_mode_we,
  input  wire logic               range_mode_wdata,
  output logic                    empty,
  input  wire logic               pop,
  output logic [11:0]             dac_code
);
  import dcpi_pkg::*;

  // Range mode register; the user must change it only between commands, the block does not enforce it.
  logic  range_mode;
  item_t front_item, q_item;
  logic  q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_mode <= 1'b0;
    end else if (range_mode_we) begin
      range_mode <= range_mode_wdata;
    end
  end

  // The front end classifies the incoming beat combinationally; the queue
  // registers it on acceptance.
  dcpi_front #(.CHANNELS(CHANNELS)) u_front (
    .cmd         (cmd),
    .voltage_mv  (voltage_mv),
    .channel     (channel),
    .point_index (point_index),
    .code_value  (code_value),
    .mode        (range_mode),
    .item        (front_item)
  );

  dcpi_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_item (front_item),
    .full    (full),
    .rd_en   (q_pop),
    .rd_item (q_item),
    .empty   (q_empty)
  );

  // The back end owns the calibration store and the result register.
  dcpi_back #(.CHANNELS(CHANNELS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_item   (q_item),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .dac_code (dac_code)
  );

endmodule
`default_nettype wire

// ===== rtl/dcpi_front.sv =====
// Front end: clamps the voltage, picks the segment and maps channel and code.
`default_nettype none
module dcpi_front #(
  parameter int CHANNELS = 4
) (
  input  wire logic [1:0]          cmd,
  input  wire logic signed [14:0]  voltage_mv,
  input  wire logic [2:0]          channel,
  input  wire logic [1:0]          point_index,
  input  wire logic [15:0]         code_value,
  input  wire logic                mode,
  output dcpi_pkg::item_t          item
);
  import dcpi_pkg::*;

  logic signed [14:0] lo, mid_lo, mid_hi, hi, mv_c, base;
  logic signed [15:0] diff;
  logic [1:0]         seg;

  always_comb begin
    lo     = bp_mv(mode, 2'd0);
    mid_lo = bp_mv(mode, 2'd1);
    mid_hi = bp_mv(mode, 2'd2);
    hi     = bp_mv(mode, 2'd3);

    mv_c = voltage_mv;
    if (mv_c < lo) mv_c = lo;
    if (mv_c > hi) mv_c = hi;

    // A voltage on a middle breakpoint belongs to the lower segment.
    if (mv_c <= mid_lo) begin
      seg = 2'd0;
    end else if (mv_c <= mid_hi) begin
      seg = 2'd1;
    end else begin
      seg = 2'd2;
    end
    base = bp_mv(mode, seg);
    diff = 16'(mv_c) - 16'(base);

    item.cmd  = cmd;
    item.mode = mode;
    item.ch   = (32'(channel) < CHANNELS) ? channel : 3'd0;
    item.pt   = point_index;
    item.seg  = seg;
    item.dx   = diff[11:0];
    item.code = (code_value > 16'(CODE_MAX)) ? CODE_MAX : code_value[11:0];
  end

endmodule
`default_nettype wire

// ===== rtl/dcpi_queue.sv =====
// Two-entry queue of classified commands between the front and back ends.
`default_nettype none
module dcpi_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire dcpi_pkg::item_t wr_item,
  output logic                 full,
  input  wire logic            rd_en,
  output dcpi_pkg::item_t      rd_item,
  output logic                 empty
);
  import dcpi_pkg::*;

  item_t      entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      entries[wr_ptr] <= wr_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en && !full) wr_ptr <= ~wr_ptr;
      if (rd_en && !empty) rd_ptr <= ~rd_ptr;
      case ({wr_en && !full, rd_en && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dcpi_back.sv =====
// Back end: calibration store, interpolation sequencer and result register.
`default_nettype none
module dcpi_back #(
  parameter int CHANNELS = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dcpi_pkg::item_t q_item,
  input  wire logic            q_empty,
  output logic                 q_pop,
  input  wire logic            pop,
  output logic                 empty,
  output logic [11:0]          dac_code
);
  import dcpi_pkg::*;

  localparam int DEPTH = 8 * CHANNELS;
  localparam int AW    = $clog2(DEPTH);

  logic [11:0]      mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [11:0]      rd_data;
  logic             rd_valid;
  logic [1:0]       rd_pt;
  logic [11:0]      rd_val;

  back_state_t state, state_next;
  item_t       cur;
  logic [11:0] y0;
  logic        neg;
  logic [23:0] acc;
  logic [48:0] prod;
  logic        out_valid;
  logic [11:0] out_code_q;

  logic [AW-1:0]      rd_addr;
  logic               start, wr_en;
  logic signed [12:0] dy;
  logic [11:0]        abs_dy;
  logic [12:0]        quot;
  logic signed [14:0] y_sum;
  logic [11:0]        y_sat;

  function automatic logic [AW-1:0] addr_of(input logic m, input logic [2:0] c,
                                            input logic [1:0] p);
    return AW'(32'(m) * (4 * CHANNELS) + 32'(c) * 4 + 32'(p));
  endfunction

  assign empty    = !out_valid;
  assign dac_code = out_code_q;
  assign rd_val   = rd_valid ? rd_data : ideal_code(rd_pt);

  always_comb begin
    state_next = state;
    start      = 1'b0;
    wr_en      = 1'b0;
    rd_addr    = addr_of(cur.mode, cur.ch, cur.pt);
    case (state)
      ST_IDLE: begin
        start = !q_empty && !out_valid;
        if (q_item.cmd == CMD_CONVERT) begin
          rd_addr = addr_of(q_item.mode, q_item.ch, q_item.seg);
        end else begin
          rd_addr = addr_of(q_item.mode, q_item.ch, q_item.pt);
        end
        wr_en = start && (q_item.cmd == CMD_WRITE);
        if (start) begin
          if (q_item.cmd == CMD_CONVERT) begin
            state_next = ST_SEG_HI;
          end else if (q_item.cmd == CMD_READ) begin
            state_next = ST_READ;
          end
        end
      end
      ST_SEG_HI: begin
        rd_addr    = addr_of(cur.mode, cur.ch, cur.seg + 2'd1);
        state_next = ST_MUL;
      end
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  state_next = ST_FIN;
      ST_FIN:  state_next = ST_IDLE;
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign q_pop = start;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Calibration store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[rd_addr] <= q_item.code;
    end
    rd_data  <= mem[rd_addr];
    rd_valid <= valid[rd_addr];
    rd_pt    <= (state == ST_SEG_HI) ? cur.seg + 2'd1 :
                (state == ST_IDLE && q_item.cmd == CMD_CONVERT) ? q_item.seg :
                (state == ST_IDLE) ? q_item.pt : cur.pt;
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[rd_addr] <= 1'b1;
    end
  end

  always_comb begin
    dy     = $signed({1'b0, rd_val}) - $signed({1'b0, y0});
    abs_dy = dy[12] ? 12'(-dy) : dy[11:0];
    quot   = prod[RECIP_SHIFT +: 13];
    y_sum  = neg ? 15'({3'b000, y0}) - 15'({2'b00, quot})
                 : 15'({3'b000, y0}) + 15'({2'b00, quot});
    if (y_sum < 15'sd0) begin
      y_sat = 12'd0;
    end else if (y_sum > 15'(CODE_MAX)) begin
      y_sat = CODE_MAX;
    end else begin
      y_sat = y_sum[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) cur <= q_item;
    case (state)
      ST_SEG_HI: y0 <= rd_val;
      ST_MUL: begin
        neg <= dy[12];
        acc <= 24'(cur.dx) * 24'(abs_dy) +
               24'((cur.seg == 2'd2) ? HALF_4000 : HALF_3000);
      end
      ST_DIV: prod <= acc * ((cur.seg == 2'd2) ? RECIP_4000 : RECIP_3000);
      default: ;
    endcase

    if (start) begin
      if (q_item.cmd == CMD_WRITE) begin
        out_code_q <= q_item.code;
      end else if (q_item.cmd != CMD_CONVERT && q_item.cmd != CMD_READ) begin
        out_code_q <= 12'd0;
      end
    end else if (state == ST_READ) begin
      out_code_q <= rd_val;
    end else if (state == ST_FIN) begin
      out_code_q <= y_sat;
    end

    if (rst) begin
      out_valid <= 1'b0;
    end else if (start && q_item.cmd != CMD_CONVERT && q_item.cmd != CMD_READ) begin
      out_valid <= 1'b1;
    end else if (state == ST_READ || state == ST_FIN) begin
      out_valid <= 1'b1;
    end else if (pop && out_valid) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== test/dac_calibrated_piecewise_interp_test.sv =====
// Self-checking testbench for the calibrated piecewise-linear DAC code converter.
`timescale 1ns / 100ps

module dac_calibrated_piecewise_interp_test;
  import dcpi_pkg::*;

  // The package names the three live commands; the fourth code does nothing.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int NCH = 4;
  localparam int NPT = 4;
  localparam int CYCLE_LIMIT = 400000;
  // Cycles allowed after the last beat, which also covers a command still in flight.
  localparam int SETTLE_CYCLES = 16;

  // Breakpoints in mV for each range mode and the ideal codes the store wakes up with.
  localparam int BREAK_MV [2][NPT] = '{'{-3000, 0, 3000, 7000}, '{0, 3000, 6000, 10000}};
  localparam int IDEAL_CODE [NPT] = '{0, 1229, 2457, 4095};

  typedef struct {
    logic [1:0]  op;
    logic [11:0] code;
  } pending_code_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [1:0] cmd = CMD_CONVERT;
  logic signed [14:0] voltage_mv = '0;
  logic [2:0] channel = '0;
  logic [1:0] point_index = '0;
  logic [15:0] code_value = '0;
  logic range_mode_we = 1'b0;
  logic range_mode_wdata = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [11:0] dac_code;

  // Shadow copy of the block's state: calibration store per mode and channel,
  // and the range mode that was last written.
  logic [11:0] cal_store [2][NCH][NPT];
  logic        cur_mode;

  pending_code_t pending_codes [$];
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;

  dac_calibrated_piecewise_interp #(
    .CHANNELS(NCH)
  ) u_top (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .cmd              (cmd),
    .voltage_mv       (voltage_mv),
    .channel          (channel),
    .point_index      (point_index),
    .code_value       (code_value),
    .range_mode_we    (range_mode_we),
    .range_mode_wdata (range_mode_wdata),
    .empty            (empty),
    .pop              (pop),
    .dac_code         (dac_code)
  );

  always #4 clk = ~clk;

  // Straight-line interpolation between two stored codes. The products stay
  // well inside 32 bits, and integer division truncates toward zero, so adding
  // or subtracting half the span first rounds half away from zero.
  function automatic logic [11:0] lerp_code(int v, int x0, int x1, int y0, int y1);
    int span;
    int prod;
    int step;
    int y;
    span = x1 - x0;
    prod = (v - x0) * (y1 - y0);
    if (prod >= 0) step = (prod + span / 2) / span;
    else step = (prod - span / 2) / span;
    y = y0 + step;
    if (y < 0) y = 0;
    if (y > 4095) y = 4095;
    return y[11:0];
  endfunction

  // Works out the one beat a command yields and applies any store update.
  function automatic logic [11:0] calibrated_code(logic [1:0] op, logic signed [14:0] mv_in,
                                                  logic [2:0] ch_in, logic [1:0] pt,
                                                  logic [15:0] val);
    int mv;
    int ch;
    int x [NPT];
    logic [11:0] result;
    mv = mv_in;
    ch = (ch_in >= NCH) ? 0 : ch_in;
    x = BREAK_MV[cur_mode];
    result = '0;
    case (op)
      CMD_CONVERT: begin
        // Clamp to the mode range, then pick the segment; a voltage sitting on
        // a middle breakpoint belongs to the segment below it.
        if (mv < x[0]) mv = x[0];
        if (mv > x[3]) mv = x[3];
        if (mv <= x[1]) begin
          result = lerp_code(mv, x[0], x[1], cal_store[cur_mode][ch][0],
                             cal_store[cur_mode][ch][1]);
        end else if (mv <= x[2]) begin
          result = lerp_code(mv, x[1], x[2], cal_store[cur_mode][ch][1],
                             cal_store[cur_mode][ch][2]);
        end else begin
          result = lerp_code(mv, x[2], x[3], cal_store[cur_mode][ch][2],
                             cal_store[cur_mode][ch][3]);
        end
      end
      CMD_WRITE: begin
        result = (val > 16'(CODE_MAX)) ? CODE_MAX : val[11:0];
        cal_store[cur_mode][ch][pt] = result;
      end
      CMD_READ: begin
        result = cal_store[cur_mode][ch][pt];
      end
      default: begin
        result = '0;
      end
    endcase
    return result;
  endfunction

  // Presents one command and holds it until the block takes it. Push stays
  // high across back-to-back commands; it only drops while the sender idles.
  task automatic send_command(logic [1:0] op, logic signed [14:0] mv, logic [2:0] ch,
                              logic [1:0] pt, logic [15:0] val);
    pending_code_t entry;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    cmd <= op;
    voltage_mv <= mv;
    channel <= ch;
    point_index <= pt;
    code_value <= val;
    // Values read right after the edge are the ones the block saw at it.
    do @(posedge clk); while (full);
    entry.op = op;
    entry.code = calibrated_code(op, mv, ch, pt, val);
    pending_codes.push_back(entry);
  endtask

  // Stops sending and waits for every outstanding beat, then lets the back
  // end settle so nothing is still in flight.
  task automatic drain_results();
    push <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The range mode is captured with each command, so it only changes while
  // the block is quiet.
  task automatic set_range_mode(logic mode);
    drain_results();
    range_mode_we <= 1'b1;
    range_mode_wdata <= mode;
    @(posedge clk);
    range_mode_we <= 1'b0;
    cur_mode = mode;
  endtask

  // Fresh from reset, mode 0: conversions across the ideal table, including
  // voltages far outside the range and right on -3000, 0 and 3000, plus a read.
  task automatic test_ideal_conversions();
    send_command(CMD_CONVERT, -15'sd16384, 3'd0, 2'd0, 16'd0);
    send_command(CMD_CONVERT, 15'sd16383, 3'd1, 2'd3, 16'hffff);
    send_command(CMD_CONVERT, -15'sd3000, 3'd2, 2'd0, 16'd0);
    send_command(CMD_CONVERT, 15'sd0, 3'd3, 2'd0, 16'd0);
    send_command(CMD_CONVERT, 15'sd1, 3'd3, 2'd0, 16'd0);
    send_command(CMD_CONVERT, -15'sd1, 3'd0, 2'd0, 16'd0);
    send_command(CMD_CONVERT, 15'sd3000, 3'd1, 2'd0, 16'd0);
    send_command(CMD_READ, 15'sd0, 3'd2, 2'd3, 16'd0);
  endtask

  // Writes and reads of calibration points: an oversized code saturates, and
  // a channel beyond the last one lands on channel 0. The unused command
  // leaves the store alone and gives a zero beat.
  task automatic test_calibration_points();
    send_command(CMD_WRITE, 15'sd0, 3'd1, 2'd2, 16'hffff);
    send_command(CMD_READ, 15'sd0, 3'd1, 2'd2, 16'd0);
    send_command(CMD_WRITE, 15'sd0, 3'd5, 2'd1, 16'd0);
    send_command(CMD_READ, 15'sd0, 3'd0, 2'd1, 16'd0);
    send_command(CMD_WRITE, 15'sd0, 3'd7, 2'd3, 16'd4096);
    send_command(CMD_UNUSED, 15'sd1234, 3'd0, 2'd3, 16'd77);
    send_command(CMD_READ, 15'sd0, 3'd4, 2'd3, 16'd0);
    send_command(CMD_CONVERT, 15'sd1500, 3'd6, 2'd0, 16'd0);
  endtask

  // Mode 1 uses its own bank and breakpoints; values below zero clamp low.
  task automatic test_range_modes();
    set_range_mode(1'b1);
    send_command(CMD_CONVERT, -15'sd5000, 3'd0, 2'd0, 16'd0);
    send_command(CMD_CONVERT, 15'sd3000, 3'd1, 2'd0, 16'd0);
    send_command(CMD_CONVERT, 15'sd6000, 3'd1, 2'd0, 16'd0);
    send_command(CMD_CONVERT, 15'sd10000, 3'd2, 2'd0, 16'd0);
    send_command(CMD_CONVERT, 15'sd12000, 3'd3, 2'd0, 16'd0);
    send_command(CMD_READ, 15'sd0, 3'd1, 2'd2, 16'd0);
    set_range_mode(1'b0);
  endtask

  // Random traffic in one range mode under one idling profile. Mostly
  // conversions aimed at the range and its breakpoints, with enough writes to
  // keep reshaping the store, including falling segments.
  task automatic test_random_traffic(int count, logic mode, int idle_pct, int stall_pct);
    int pick;
    int mv;
    logic [1:0] op;
    logic [15:0] val;
    set_range_mode(mode);
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 55) op = CMD_CONVERT;
      else if (pick < 75) op = CMD_WRITE;
      else if (pick < 95) op = CMD_READ;
      else op = CMD_UNUSED;
      case ($urandom_range(3))
        0: mv = $signed(15'($urandom));
        1: mv = BREAK_MV[mode][0] + $urandom_range(BREAK_MV[mode][3] - BREAK_MV[mode][0]);
        2: mv = BREAK_MV[mode][$urandom_range(NPT - 1)] + $urandom_range(4) - 2;
        default: mv = $urandom_range(13000) - 3000;
      endcase
      case ($urandom_range(2))
        0: val = 16'($urandom);
        1: val = 16'($urandom_range(4095));
        default: begin
          case ($urandom_range(3))
            0: val = 16'd0;
            1: val = 16'd4095;
            2: val = 16'd4096;
            default: val = 16'hffff;
          endcase
        end
      endcase
      send_command(op, 15'(mv), 3'($urandom_range(7)), 2'($urandom_range(NPT - 1)), val);
    end
  endtask

  // Result side: every accepted beat is matched against the oldest expected
  // code, and the ready-to-take decision for the next edge is drawn here too.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_codes.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual dac_code %0d", $time, dac_code);
        error_count <= error_count + 1;
      end else begin
        if (dac_code !== pending_codes[0].code) begin
          $display("%0t: dac_code mismatch (cmd %0d), expected %0d, actual %0d", $time,
                   pending_codes[0].op, pending_codes[0].code, dac_code);
          error_count <= error_count + 1;
        end
        void'(pending_codes.pop_front());
      end
    end
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    cur_mode = 1'b0;
    for (int m = 0; m < 2; m++) begin
      for (int c = 0; c < NCH; c++) begin
        for (int p = 0; p < NPT; p++) cal_store[m][c][p] = 12'(IDEAL_CODE[p]);
      end
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_ideal_conversions();
    test_calibration_points();
    test_range_modes();

    // Idling profiles: none, sender only, receiver only, both lightly.
    test_random_traffic(250, 1'b0, 0, 0);
    test_random_traffic(250, 1'b1, 61, 0);
    test_random_traffic(250, 1'b0, 0, 61);
    test_random_traffic(250, 1'b1, 10, 10);
    test_random_traffic(250, 1'b1, 0, 61);
    test_random_traffic(250, 1'b0, 61, 0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== dac_calibrated_piecewise_interp.f =====
rtl/dcpi_pkg.sv
rtl/dcpi_front.sv
rtl/dcpi_queue.sv
rtl/dcpi_back.sv
rtl/dac_calibrated_piecewise_interp.sv
test/dac_calibrated_piecewise_interp_test.sv
